>>> rtl/skt_pkg.sv
// Shared types and constants for the sorted key table.
// Holds the request/response beat structs and the stored entry layout.
// No dependencies.
package skt_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int KEY_W     = 32;
  localparam int PAY_W     = 32;
  localparam int CNT_W     = 5;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef struct packed {
    op_t                     req_type;
    logic signed [KEY_W-1:0] req_key;
    logic [PAY_W-1:0]        req_payload;
  } req_t;

  typedef struct packed {
    logic             success;
    logic [PAY_W-1:0] found_payload;
    logic [CNT_W-1:0] entry_count;
  } rsp_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [PAY_W-1:0]        payload;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

>>> rtl/skt_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Used for the entry store of the sorted key table. No dependencies.
module skt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/sorted_key_table.sv
// Sorted key table top level: sequencer around one entry RAM.
// Depends on skt_pkg and skt_ram.
//
//   channel | dir | payload | beat taken when
//   in_     | in  | req_t   | in_valid  && in_ready
//   out_    | out | rsp_t   | out_valid && out_ready
//
// Every entry visit is a RAM read state (S_RD) then a compare/write state (S_CHK).
// Insert walks down from the top entry to the one below the insert point,
// or to entry 0; an insert into an empty table writes entry 0 directly.
// Delete walks all count entries, search stops at the first hit.
// Clear and failed full/empty requests go from idle straight to the result state.
// Reset empties the table at once (fill count only); no RAM sweep.
// in_ready is high only while idle; a result held on out_ stalls the next finish.
module sorted_key_table
  import skt_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  req_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output rsp_t out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_RD   = 5'b00010,
    S_CHK  = 5'b00100,
    S_PUT  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t           state_r, state_nxt;
  req_t             req_r, req_nxt;
  logic [AW-1:0]    idx_r, idx_nxt;
  logic [AW-1:0]    put_r, put_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             found_r, found_nxt;
  logic             succ_r, succ_nxt;
  logic [PAY_W-1:0] fpay_r, fpay_nxt;
  logic             out_valid_r, out_valid_nxt;
  rsp_t             out_data_r, out_data_nxt;

  logic          we;
  logic [AW-1:0] waddr;
  entry_t        wdata;
  entry_t        rd;
  logic          last;
  logic          hit;

  skt_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(idx_r),
    .rdata(rd)
  );

  assign last = (CW'(idx_r) == (count_r - CW'(1)));
  assign hit  = (rd.key == req_r.req_key);

  always_comb begin
    state_nxt     = state_r;
    req_nxt       = req_r;
    idx_nxt       = idx_r;
    put_nxt       = put_r;
    count_nxt     = count_r;
    found_nxt     = found_r;
    succ_nxt      = succ_r;
    fpay_nxt      = fpay_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    we            = 1'b0;
    waddr         = idx_r;
    wdata         = rd;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          req_nxt   = in_data;
          succ_nxt  = 1'b0;
          fpay_nxt  = '0;
          found_nxt = 1'b0;
          idx_nxt   = '0;
          state_nxt = S_OUT;
          case (in_data.req_type)
            OP_INSERT: begin
              if (count_r == '0) begin
                put_nxt   = '0;
                state_nxt = S_PUT;
              end else if (count_r != FULL) begin
                idx_nxt   = AW'(count_r - CW'(1));
                state_nxt = S_RD;
              end
            end
            OP_CLEAR: begin
              count_nxt = '0;
              succ_nxt  = 1'b1;
            end
            default: begin
              if (count_r != '0) begin
                state_nxt = S_RD;
              end
            end
          endcase
        end
      end
      S_RD: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        state_nxt = S_RD;
        case (req_r.req_type)
          OP_INSERT: begin
            if ($signed(rd.key) < $signed(req_r.req_key)) begin
              put_nxt   = idx_r + AW'(1);
              state_nxt = S_PUT;
            end else begin
              we    = 1'b1;
              waddr = idx_r + AW'(1);
              if (idx_r == '0) begin
                put_nxt   = '0;
                state_nxt = S_PUT;
              end else begin
                idx_nxt = idx_r - AW'(1);
              end
            end
          end
          OP_DELETE: begin
            if (found_r) begin
              we    = 1'b1;
              waddr = idx_r - AW'(1);
            end else if (hit) begin
              found_nxt = 1'b1;
            end
            if (last) begin
              if (found_r || hit) begin
                succ_nxt  = 1'b1;
                count_nxt = count_r - CW'(1);
              end
              state_nxt = S_OUT;
            end else begin
              idx_nxt = idx_r + AW'(1);
            end
          end
          default: begin
            if (hit) begin
              succ_nxt  = 1'b1;
              fpay_nxt  = rd.payload;
              state_nxt = S_OUT;
            end else if (last) begin
              state_nxt = S_OUT;
            end else begin
              idx_nxt = idx_r + AW'(1);
            end
          end
        endcase
      end
      S_PUT: begin
        we        = 1'b1;
        waddr     = put_r;
        wdata     = '{key: req_r.req_key, payload: req_r.req_payload};
        count_nxt = count_r + CW'(1);
        succ_nxt  = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.success       = succ_r;
          out_data_nxt.found_payload = fpay_r;
          out_data_nxt.entry_count   = CNT_W'(count_r);
          state_nxt                  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    req_r      <= req_nxt;
    idx_r      <= idx_nxt;
    put_r      <= put_nxt;
    found_r    <= found_nxt;
    succ_r     <= succ_nxt;
    fpay_r     <= fpay_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/skt_checker.sv
// Port-level checks for the sorted key table, bound to the top level.
// Depends on skt_pkg and sorted_key_table.
module skt_checker
  import skt_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input req_t in_data,
  input logic out_valid,
  input logic out_ready,
  input rsp_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat dropped or changed while stalled");

  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while a request is in progress");

  a_fail_no_payload: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.success |-> out_data.found_payload == '0)
    else $error("failed request returned a payload");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind sorted_key_table skt_checker u_skt_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

>>> sim/sorted_key_table_checker.sv
// Scoreboard for the sorted key table: watches the in_ and out_ channels,
// keeps a shadow copy of the sorted table and compares every result beat.
// Depends on skt_pkg.
module sorted_key_table_checker
  import skt_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_ready,
  input  req_t in_data,
  input  logic out_valid,
  input  logic out_ready,
  input  rsp_t out_data,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic signed [KEY_W-1:0] shadow_key [DEPTH];
  logic [PAY_W-1:0]        shadow_pay [DEPTH];
  int                      shadow_cnt;

  rsp_t rsp_due_q[$];
  int   mismatches = 0;
  int   outstanding = 0;

  assign fail_count = mismatches;
  assign pending    = outstanding;

  // Applies one request to the shadow table, returns the result it must produce.
  function automatic rsp_t table_update(req_t r);
    rsp_t rsp;
    int   pos;
    int   i;
    rsp = '0;
    pos = 0;
    case (r.req_type)
      OP_INSERT: begin
        if (shadow_cnt < DEPTH) begin
          while (pos < shadow_cnt && shadow_key[pos] < r.req_key) pos++;
          for (i = shadow_cnt; i > pos; i--) begin
            shadow_key[i] = shadow_key[i-1];
            shadow_pay[i] = shadow_pay[i-1];
          end
          shadow_key[pos] = r.req_key;
          shadow_pay[pos] = r.req_payload;
          shadow_cnt++;
          rsp.success = 1'b1;
        end
      end
      OP_DELETE: begin
        while (pos < shadow_cnt && shadow_key[pos] != r.req_key) pos++;
        if (pos < shadow_cnt) begin
          for (i = pos; i < shadow_cnt - 1; i++) begin
            shadow_key[i] = shadow_key[i+1];
            shadow_pay[i] = shadow_pay[i+1];
          end
          shadow_cnt--;
          rsp.success = 1'b1;
        end
      end
      OP_SEARCH: begin
        while (pos < shadow_cnt && shadow_key[pos] != r.req_key) pos++;
        if (pos < shadow_cnt) begin
          rsp.success       = 1'b1;
          rsp.found_payload = shadow_pay[pos];
        end
      end
      default: begin
        shadow_cnt  = 0;
        rsp.success = 1'b1;
      end
    endcase
    rsp.entry_count = shadow_cnt[CNT_W-1:0];
    return rsp;
  endfunction

  always @(posedge clk) begin : watch
    rsp_t want;
    if (!rst_n) begin
      rsp_due_q.delete();
      shadow_cnt  = 0;
      outstanding = 0;
    end else begin
      if (in_valid && in_ready) begin
        rsp_due_q.push_back(table_update(in_data));
      end
      if (out_valid && out_ready) begin
        if (rsp_due_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result beat with nothing expected: success=%0b payload=%h count=%0d",
                     $realtime, out_data.success, out_data.found_payload,
                     out_data.entry_count);
          end
        end else begin
          want = rsp_due_q.pop_front();
          if (out_data.success !== want.success ||
              out_data.found_payload !== want.found_payload ||
              out_data.entry_count !== want.entry_count) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch exp success=%0b payload=%h count=%0d", $realtime,
                       want.success, want.found_payload, want.entry_count);
              $display("%0t:          got success=%0b payload=%h count=%0d", $realtime,
                       out_data.success, out_data.found_payload, out_data.entry_count);
            end
          end
        end
      end
      outstanding = rsp_due_q.size();
    end
  end

endmodule

>>> sim/sorted_key_table_tb.sv
// Testbench top for the sorted key table: clock, reset, request and
// result-ready stimulus, and the final verdict.
// Depends on skt_pkg, sorted_key_table and sorted_key_table_checker.
module sorted_key_table_tb
  import skt_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 700;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  req_t in_data;
  logic out_valid;
  logic out_ready;
  rsp_t out_data;
  int   fail_count;
  int   pending;

  int   cycle_cnt = 0;
  int   burst_left = 0;

  always #6 clk = ~clk;

  sorted_key_table DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  sorted_key_table_checker u_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("FAIL sorted_key_table");
      $finish;
    end
  end

  // Sends one request beat; bursts of beats are separated by random gaps.
  task automatic send_req(op_t op, logic [KEY_W-1:0] key, logic [PAY_W-1:0] pay);
    req_t r;
    r.req_type    = op;
    r.req_key     = key;
    r.req_payload = pay;
    if (burst_left == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 7)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
  endtask

  // Mostly a small key pool so deletes and searches hit, plus the extremes.
  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return 32'($urandom_range(0, 7)) - 32'd4;
    if (r == 6) return 32'h8000_0000 + 32'($urandom_range(0, 2));
    if (r == 7) return 32'h7fff_ffff - 32'($urandom_range(0, 2));
    return $urandom();
  endfunction

  // Result-ready pattern: stretches of steady, random and periodic stalls,
  // plus one long hold-off so the table backs up into the request side.
  initial begin : receiver
    int rx_cycles;
    int stretch_mode;
    int len;
    int k;
    rx_cycles = 0;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stretch_mode = $urandom_range(0, 3);
      len = $urandom_range(16, 96);
      for (k = 0; k < len; k++) begin
        @(negedge clk);
        rx_cycles++;
        if (rx_cycles >= 1500 && rx_cycles < 1900) begin
          out_ready <= 1'b0;
        end else begin
          case (stretch_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= 1'($urandom_range(0, 1));
            2:       out_ready <= ($urandom_range(0, 7) != 0);
            default: out_ready <= ((k % 4) != 3);
          endcase
        end
      end
    end
  end

  initial begin : stimulus
    int   n;
    int   mix;
    int   r;
    op_t  op;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    send_req(OP_DELETE, 32'd5, 32'h1234_5678);
    send_req(OP_SEARCH, 32'd0, 32'hffff_ffff);
    send_req(OP_INSERT, 32'h7fff_ffff, 32'hffff_ffff);
    send_req(OP_INSERT, 32'h8000_0000, 32'h0000_0000);
    send_req(OP_INSERT, 32'd0, 32'ha5a5_a5a5);
    send_req(OP_INSERT, 32'hffff_ffff, 32'h5a5a_5a5a);
    send_req(OP_INSERT, 32'd7, 32'h0000_0111);
    send_req(OP_INSERT, 32'd7, 32'h0000_0222);
    send_req(OP_SEARCH, 32'd7, 32'h0);
    send_req(OP_SEARCH, 32'h7fff_ffff, 32'h0);
    send_req(OP_SEARCH, 32'h8000_0000, 32'hffff_ffff);
    send_req(OP_SEARCH, 32'd3, 32'h0);
    send_req(OP_DELETE, 32'd7, 32'h0);
    send_req(OP_SEARCH, 32'd7, 32'h0);
    send_req(OP_DELETE, 32'd100, 32'h0);
    send_req(OP_DELETE, 32'h8000_0000, 32'h0);
    send_req(OP_DELETE, 32'h7fff_ffff, 32'h0);
    send_req(OP_CLEAR, 32'hffff_ffff, 32'hffff_ffff);
    send_req(OP_SEARCH, 32'd0, 32'h0);
    send_req(OP_DELETE, 32'd0, 32'h0);
    send_req(OP_INSERT, 32'd1, 32'hdead_beef);
    send_req(OP_CLEAR, 32'd0, 32'd0);

    mix = 0;
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) mix = (n == 0) ? 0 : $urandom_range(0, 2);
      r = $urandom_range(0, 99);
      case (mix)
        0:       op = (r < 75) ? OP_INSERT : (r < 85) ? OP_DELETE :
                      (r < 98) ? OP_SEARCH : OP_CLEAR;
        1:       op = (r < 25) ? OP_INSERT : (r < 70) ? OP_DELETE :
                      (r < 98) ? OP_SEARCH : OP_CLEAR;
        default: op = (r < 45) ? OP_INSERT : (r < 70) ? OP_DELETE :
                      (r < 98) ? OP_SEARCH : OP_CLEAR;
      endcase
      send_req(op, pick_key(), $urandom());
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (48) @(negedge clk);
    if (fail_count == 0) begin
      $display("PASS sorted_key_table");
    end else begin
      $display("FAIL sorted_key_table");
    end
    $finish;
  end

endmodule
